// File: rtl/core/kt_pkg.sv
`default_nettype none
package kt_pkg;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MSTART,
		ST_MWAIT,
		ST_DSTART,
		ST_DWAIT,
		ST_OUT
	} state_t;

	// micro-operations of one update, in issue order
	typedef enum logic [3:0] {
		OP_PRED,
		OP_DP11,
		OP_P00,
		OP_P11,
		OP_K0,
		OP_K1,
		OP_BIAS,
		OP_ANG,
		OP_P10C,
		OP_P11C,
		OP_P00C,
		OP_P01C
	} op_t;

	// product scaling
	typedef enum logic [1:0] {
		SH16,
		SH24,
		SH32
	} shift_t;

	// request kinds carried in tuser
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_SET    = 1'b1;

	// register indexes
	localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
	localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
	localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

	localparam logic [23:0] ANGLE_NOISE_RST = 24'd16777;
	localparam logic [23:0] BIAS_NOISE_RST  = 24'd50332;
	localparam logic [23:0] MEAS_NOISE_RST  = 24'd503316;

	typedef struct packed {
		logic load;
		logic mul_start;
		logic div_start;
		logic out_load;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic s_pos;
		logic out_free;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		logic signed [47:0] r;
		if (v > 64'sd140737488355327) r = 48'sh7FFFFFFFFFFF;
		else if (v < -64'sd140737488355328) r = 48'sh800000000000;
		else r = v[47:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/kalman_tilt_angle_filter_core.sv
// channel    dir  handshake          payload
// s_axis     in   s_tvalid/s_tready  tdata: angle, rate, step; tuser: kind
// m_axis     out  m_tvalid/m_tready  tdata: filtered angle, unbiased rate
// cfg        in   cfg_we             cfg_index, cfg_data (no read-back)
//
// set-angle request: result loaded from ST_OUT once the result register is free
// update request: 10 multiplies plus 2 divides or none, run on the bit-serial
//   multiplier and divider; the result is then loaded from ST_OUT once the
//   result register is free
// one request in flight; a waiting result does not block the next accept
// arst_n clears state, covariance and registers to their reset values
`default_nettype none
module kalman_tilt_angle_filter_core (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire logic [79:0]  s_tdata,   // measured_angle, gyro_rate, time_step
	input  wire logic [0:0]   s_tuser,   // kind
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic [63:0]       m_tdata,   // filtered_angle, unbiased_rate
	input  wire               cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [23:0]  cfg_data
);

	kt_pkg::cmd_t cmd;
	kt_pkg::sts_t sts;

	kt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.kind     (s_tuser[0]),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kt_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (s_tuser[0]),
		.in_data   (s_tdata[76:0]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

// File: rtl/core/kt_mul.sv
`default_nettype none
module kt_mul (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire logic signed [63:0]   a,
	input  wire logic signed [63:0]   b,
	input  wire kt_pkg::shift_t       sh,
	output logic                      done,
	output logic signed [63:0]        res
);

	logic              busy_q, post_q, done_q, neg_q;
	logic [5:0]        cnt_q;
	logic [62:0]       ua_q, lo_q;
	logic [63:0]       hi_q;
	kt_pkg::shift_t    sh_q;
	logic signed [63:0] res_q;

	logic [63:0]  a_mag, b_mag, sum;
	logic [127:0] rnd, shifted;
	logic [62:0]  m;

	// operand magnitudes
	assign a_mag = a[63] ? 64'(-a) : 64'(a);
	assign b_mag = b[63] ? 64'(-b) : 64'(b);
	assign sum   = hi_q + (lo_q[0] ? {1'b0, ua_q} : 64'd0);

	// round to nearest on magnitude, then scale and clamp
	always_comb begin
		unique case (sh_q)
			kt_pkg::SH16: rnd = {1'b0, hi_q, lo_q} + (128'd1 << 15);
			kt_pkg::SH24: rnd = {1'b0, hi_q, lo_q} + (128'd1 << 23);
			default:      rnd = {1'b0, hi_q, lo_q} + (128'd1 << 31);
		endcase
		unique case (sh_q)
			kt_pkg::SH16: shifted = rnd >> 16;
			kt_pkg::SH24: shifted = rnd >> 24;
			default:      shifted = rnd >> 32;
		endcase
		if (shifted > (128'd1 << 62)) m = 63'd1 << 62;
		else m = shifted[62:0];
	end

	// shift-add over one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			post_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd62) begin
					busy_q <= 1'b0;
					post_q <= 1'b1;
				end
			end else if (post_q) begin
				post_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= a_mag[62:0];
			lo_q  <= b_mag[62:0];
			hi_q  <= '0;
			neg_q <= a[63] ^ b[63];
			sh_q  <= sh;
		end else if (busy_q) begin
			hi_q <= {1'b0, sum[63:1]};
			lo_q <= {sum[0], lo_q[62:1]};
		end else if (post_q) begin
			res_q <= neg_q ? -$signed({1'b0, m}) : $signed({1'b0, m});
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// File: rtl/core/kt_div.sv
`default_nettype none
module kt_div (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire logic signed [47:0]   num,
	input  wire logic [48:0]          den,
	output logic                      done,
	output logic signed [63:0]        res
);

	localparam logic [61:0] HALF_LIM = 62'd1 << 61;

	logic              busy_q, post_q, done_q, neg_q, sat_q;
	logic [6:0]        cnt_q;
	logic [48:0]       rem_q;
	logic [79:0]       q_q;
	logic [48:0]       ud_q;
	logic signed [63:0] res_q;

	logic [47:0] un;
	logic [49:0] rs;
	logic        ge;
	logic [62:0] m;

	assign un = num[47] ? 48'(-num) : 48'(num);
	assign rs = {rem_q, q_q[79]};
	assign ge = rs >= {1'b0, ud_q};

	// clamp the quotient as the saturating shift loop does
	always_comb begin
		if (sat_q) m = 63'd1 << 62;
		else m = {1'b0, q_q[61:0]};
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			post_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd79) begin
					busy_q <= 1'b0;
					post_q <= 1'b1;
				end
			end else if (post_q) begin
				post_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= {un, 32'd0};
			rem_q <= '0;
			ud_q  <= den;
			neg_q <= num[47];
			sat_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? 49'(rs - {1'b0, ud_q}) : rs[48:0];
			q_q   <= {q_q[78:0], ge};
			// partial quotient kept modulo 2^62 above half the limit saturates
			if (cnt_q >= 7'd62 && q_q[61:0] > HALF_LIM) sat_q <= 1'b1;
		end else if (post_q) begin
			res_q <= neg_q ? -$signed({1'b0, m}) : $signed({1'b0, m});
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// File: rtl/core/kt_dpath.sv
`default_nettype none
module kt_dpath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire kt_pkg::cmd_t   cmd,
	output kt_pkg::sts_t        sts,
	input  wire                 kind,
	input  wire logic [76:0]    in_data,
	input  wire                 cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [23:0]    cfg_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [63:0]         out_data
);

	logic [23:0] qa_q, qb_q, mr_q;
	logic signed [31:0] angle_q, bias_q, rate_q;
	logic signed [47:0] p00_q, p01_q, p10_q, p11_q;
	logic signed [24:0] meas_q;
	logic [23:0] dt_q;
	logic signed [63:0] dp11_q, k0_q, k1_q;
	logic signed [31:0] oangle_q, orate_q;
	logic ovalid_q;

	logic signed [24:0] in_meas;
	logic signed [27:0] in_gyro;
	logic signed [63:0] s, t, y, ma, mb, mres, dres, dt_s;
	logic signed [47:0] dnum;
	kt_pkg::shift_t msh;
	logic mdone, ddone;

	assign in_meas = in_data[24:0];
	assign in_gyro = in_data[52:25];
	assign dt_s    = $signed({40'd0, dt_q});

	// innovation variance, predicted covariance term and innovation
	assign s = 64'(p00_q) + $signed({32'd0, mr_q, 8'd0});
	assign t = dp11_q - 64'(p01_q) - 64'(p10_q) + $signed({32'd0, qa_q, 8'd0});
	assign y = 64'(meas_q) - 64'(angle_q);

	// multiplier operand select
	always_comb begin
		ma  = dt_s;
		mb  = 64'(rate_q);
		msh = kt_pkg::SH24;
		unique case (cmd.op)
			kt_pkg::OP_PRED: begin ma = dt_s; mb = 64'(rate_q); msh = kt_pkg::SH24; end
			kt_pkg::OP_DP11: begin ma = dt_s; mb = 64'(p11_q); msh = kt_pkg::SH24; end
			kt_pkg::OP_P00:  begin ma = dt_s; mb = t; msh = kt_pkg::SH24; end
			kt_pkg::OP_P11:  begin
				ma = $signed({40'd0, qb_q}); mb = dt_s; msh = kt_pkg::SH16;
			end
			kt_pkg::OP_BIAS: begin ma = k1_q; mb = y; msh = kt_pkg::SH32; end
			kt_pkg::OP_ANG:  begin ma = k0_q; mb = y; msh = kt_pkg::SH32; end
			kt_pkg::OP_P10C: begin ma = k1_q; mb = 64'(p00_q); msh = kt_pkg::SH32; end
			kt_pkg::OP_P11C: begin ma = k1_q; mb = 64'(p01_q); msh = kt_pkg::SH32; end
			kt_pkg::OP_P00C: begin ma = k0_q; mb = 64'(p00_q); msh = kt_pkg::SH32; end
			kt_pkg::OP_P01C: begin ma = k0_q; mb = 64'(p01_q); msh = kt_pkg::SH32; end
			default: begin ma = dt_s; mb = 64'(rate_q); msh = kt_pkg::SH24; end
		endcase
	end

	assign dnum = (cmd.op == kt_pkg::OP_K1) ? p10_q : p00_q;

	kt_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (ma),
		.b      (mb),
		.sh     (msh),
		.done   (mdone),
		.res    (mres)
	);

	kt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (dnum),
		.den    (s[48:0]),
		.done   (ddone),
		.res    (dres)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= kt_pkg::ANGLE_NOISE_RST;
			qb_q <= kt_pkg::BIAS_NOISE_RST;
			mr_q <= kt_pkg::MEAS_NOISE_RST;
		end else if (cfg_we) begin
			if (cfg_index == kt_pkg::REG_ANGLE_NOISE) qa_q <= cfg_data;
			if (cfg_index == kt_pkg::REG_BIAS_NOISE) qb_q <= cfg_data;
			if (cfg_index == kt_pkg::REG_MEAS_NOISE) mr_q <= cfg_data;
		end
	end

	// filter state and writeback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			bias_q  <= '0;
			p00_q   <= '0;
			p01_q   <= '0;
			p10_q   <= '0;
			p11_q   <= '0;
		end else if (cmd.load) begin
			if (kind == kt_pkg::KIND_SET) angle_q <= 32'(in_meas);
		end else if (mdone) begin
			unique case (cmd.op)
				kt_pkg::OP_PRED: angle_q <= kt_pkg::sat32(64'(angle_q) + mres);
				kt_pkg::OP_P00: begin
					p00_q <= kt_pkg::sat48(64'(p00_q) + mres);
					p01_q <= kt_pkg::sat48(64'(p01_q) - dp11_q);
					p10_q <= kt_pkg::sat48(64'(p10_q) - dp11_q);
				end
				kt_pkg::OP_P11:  p11_q <= kt_pkg::sat48(64'(p11_q) + mres);
				kt_pkg::OP_BIAS: bias_q <= kt_pkg::sat32(64'(bias_q) + mres);
				kt_pkg::OP_ANG:  angle_q <= kt_pkg::sat32(64'(angle_q) + mres);
				kt_pkg::OP_P10C: p10_q <= kt_pkg::sat48(64'(p10_q) - mres);
				kt_pkg::OP_P11C: p11_q <= kt_pkg::sat48(64'(p11_q) - mres);
				kt_pkg::OP_P00C: p00_q <= kt_pkg::sat48(64'(p00_q) - mres);
				kt_pkg::OP_P01C: p01_q <= kt_pkg::sat48(64'(p01_q) - mres);
				default: ;
			endcase
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q <= in_meas;
			dt_q   <= in_data[76:53];
			rate_q <= kt_pkg::sat32(64'(in_gyro) - 64'(bias_q));
			k0_q   <= '0;
			k1_q   <= '0;
		end else begin
			if (mdone && cmd.op == kt_pkg::OP_DP11) dp11_q <= mres;
			if (ddone && cmd.op == kt_pkg::OP_K0) k0_q <= dres;
			if (ddone && cmd.op == kt_pkg::OP_K1) k1_q <= dres;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (cmd.out_load) ovalid_q <= 1'b1;
		else if (out_ready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			oangle_q <= angle_q;
			orate_q  <= rate_q;
		end
	end

	assign sts.mul_done = mdone;
	assign sts.div_done = ddone;
	assign sts.s_pos    = !s[63] && (s != 64'sd0);
	assign sts.out_free = !ovalid_q || out_ready;

	assign out_valid = ovalid_q;
	assign out_data  = {orate_q, oangle_q};

endmodule
`default_nettype wire

// File: rtl/core/kt_ctrl.sv
`default_nettype none
module kt_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	input  wire           kind,
	output logic          in_ready,
	input  wire kt_pkg::sts_t sts,
	output kt_pkg::cmd_t  cmd
);

	kt_pkg::state_t state_q, state_d;
	kt_pkg::op_t    op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kt_pkg::ST_IDLE;
			op_q    <= kt_pkg::OP_PRED;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	// sequencing of one request
	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.mul_start = 1'b0;
		cmd.div_start = 1'b0;
		cmd.out_load  = 1'b0;
		cmd.op        = op_q;
		unique case (state_q)
			kt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					op_d     = kt_pkg::OP_PRED;
					state_d  = (kind == kt_pkg::KIND_SET) ? kt_pkg::ST_OUT : kt_pkg::ST_MSTART;
				end
			end
			kt_pkg::ST_MSTART: begin
				cmd.mul_start = 1'b1;
				state_d = kt_pkg::ST_MWAIT;
			end
			kt_pkg::ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d = kt_pkg::ST_DWAIT;
			end
			kt_pkg::ST_MWAIT: begin
				if (sts.mul_done) begin
					state_d = kt_pkg::ST_MSTART;
					unique case (op_q)
						kt_pkg::OP_PRED: op_d = kt_pkg::OP_DP11;
						kt_pkg::OP_DP11: op_d = kt_pkg::OP_P00;
						kt_pkg::OP_P00:  op_d = kt_pkg::OP_P11;
						kt_pkg::OP_P11: begin
							op_d    = kt_pkg::OP_BIAS;
							if (sts.s_pos) begin
								op_d    = kt_pkg::OP_K0;
								state_d = kt_pkg::ST_DSTART;
							end
						end
						kt_pkg::OP_BIAS: op_d = kt_pkg::OP_ANG;
						kt_pkg::OP_ANG:  op_d = kt_pkg::OP_P10C;
						kt_pkg::OP_P10C: op_d = kt_pkg::OP_P11C;
						kt_pkg::OP_P11C: op_d = kt_pkg::OP_P00C;
						kt_pkg::OP_P00C: op_d = kt_pkg::OP_P01C;
						default:         state_d = kt_pkg::ST_OUT;
					endcase
				end
			end
			kt_pkg::ST_DWAIT: begin
				if (sts.div_done) begin
					if (op_q == kt_pkg::OP_K0) begin
						op_d    = kt_pkg::OP_K1;
						state_d = kt_pkg::ST_DSTART;
					end else begin
						op_d    = kt_pkg::OP_BIAS;
						state_d = kt_pkg::ST_MSTART;
					end
				end
			end
			kt_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = kt_pkg::ST_IDLE;
				end
			end
			default: state_d = kt_pkg::ST_IDLE;
		endcase
	end

	// an update request never produces its result in the next cycle
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == kt_pkg::KIND_UPDATE) |=> !cmd.out_load)
		else $error("update result issued too early");

	// unit completions only arrive while waiting for them
	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> state_q == kt_pkg::ST_MWAIT)
		else $error("multiplier done outside wait");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == kt_pkg::ST_DWAIT)
		else $error("divider done outside wait");

	// result register is never overwritten while still full
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result overwritten");

endmodule
`default_nettype wire
